// ===== design/icaf_pkg.sv =====
// ----------------------------------------------------------------------------
// icaf_pkg
// Shared constants, types and helpers of the attitude filter.
// ----------------------------------------------------------------------------
package icaf_pkg;

  localparam int CordicStepsDef = 16;
  localparam int AngleFracDef   = 16;
  localparam int TblLen         = 24;
  localparam int TblFrac        = 24;

  localparam logic [30:0] DtDivisor = 31'd2096000000;
  localparam logic [31:0] TrustLo   = 32'd193944617;
  localparam logic [31:0] TrustHi   = 32'd355005890;

  // gyro divisor = DivOdd * 2^DivShift; DivRecip = floor(2^37 / DivOdd) gives
  // a quotient estimate low by at most one for any 37-bit partial dividend
  localparam int          DivShift = 10;
  localparam logic [20:0] DivOdd   = 21'd2046875;
  localparam logic [16:0] DivRecip = 17'((64'd1 << 37) / 64'(DivOdd));

  // register indexes (byte address / 4)
  localparam logic [2:0] RegGyroBiasX  = 3'd0;
  localparam logic [2:0] RegGyroBiasY  = 3'd1;
  localparam logic [2:0] RegGyroBiasZ  = 3'd2;
  localparam logic [2:0] RegRollOffset = 3'd3;
  localparam logic [2:0] RegPitchOff   = 3'd4;
  localparam logic [2:0] RegAlphaGain  = 3'd5;

  localparam logic [15:0] AlphaReset = 16'd62915;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_SQY, S_SQZ, S_SQE,
    S_RS, S_RW, S_CS, S_CW, S_PS, S_PW, S_QS, S_QW, S_DW,
    S_BR1, S_BR2, S_BR3, S_BP1, S_BP2, S_BP3, S_YAW, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    DIV_IDLE, DIV_MUL, DIV_LOAD, DIV_EST, DIV_FIX, DIV_STORE
  } div_phase_e;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [33:0] atan_deg(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/icaf_isqrt.sv =====
// ----------------------------------------------------------------------------
// icaf_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module icaf_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] radicand_i,
  output logic        done_o,
  output logic [15:0] root_o
);
  import icaf_pkg::*;

  logic        busy_q, done_q;
  logic [31:0] s_q, bit_q;
  logic [32:0] r_q, trial;

  assign trial = r_q + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 32'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= 32'h4000_0000;
    end else if (busy_q) begin
      if ({1'b0, s_q} >= trial) begin
        s_q <= s_q - trial[31:0];
        r_q <= (r_q >> 1) + {1'b0, bit_q};
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[15:0];

endmodule

// ===== design/icaf_cordic.sv =====
// ----------------------------------------------------------------------------
// icaf_cordic
// Vectoring CORDIC atan2 in degrees, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module icaf_cordic #(
  parameter int CORDIC_STEPS    = icaf_pkg::CordicStepsDef,
  parameter int ANGLE_FRAC_BITS = icaf_pkg::AngleFracDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] y_i,
  input  logic        [15:0] x_i,
  output logic               done_o,
  output logic signed [33:0] angle_o
);
  import icaf_pkg::*;

  localparam int NSteps = (CORDIC_STEPS < TblLen) ? CORDIC_STEPS : TblLen;
  localparam int RndSh  = TblFrac - ANGLE_FRAC_BITS;

  logic               busy_q, done_q, zero_q;
  logic [4:0]         cnt_q;
  logic signed [33:0] x_q, y_q, z_q, xs, ys, rnd;

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign rnd = (z_q + (34'sd1 <<< (RndSh - 1))) >>> RndSh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 5'(NSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= {6'b0, x_i, 12'b0};
      y_q    <= {{5{y_i[16]}}, y_i, 12'b0};
      z_q    <= '0;
      cnt_q  <= '0;
      zero_q <= (x_i == 16'd0) && (y_i == 17'sd0);
    end else if (busy_q) begin
      if (!y_q[33]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_deg(cnt_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_deg(cnt_q);
      end
      cnt_q <= cnt_q + 5'd1;
    end
  end

  assign done_o  = done_q;
  assign angle_o = zero_q ? 34'sd0 : rnd;

endmodule

// ===== design/icaf_gyro_div.sv =====
// ----------------------------------------------------------------------------
// icaf_gyro_div
// Gyro angle increments: rate times elapsed time over a constant, by
// reciprocal multiplication on 16-bit limbs, the three axes one after another.
// ----------------------------------------------------------------------------
module icaf_gyro_div #(
  parameter int ANGLE_FRAC_BITS = icaf_pkg::AngleFracDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [21:0]                rate_x_i,
  input  logic signed [21:0]                rate_y_i,
  input  logic signed [21:0]                rate_z_i,
  input  logic        [19:0]                us_i,
  output logic                              done_o,
  output logic signed [ANGLE_FRAC_BITS+12:0] delta_x_o,
  output logic signed [ANGLE_FRAC_BITS+12:0] delta_y_o,
  output logic signed [ANGLE_FRAC_BITS+12:0] delta_z_o
);
  import icaf_pkg::*;

  localparam int QB    = ANGLE_FRAC_BITS + 12;
  localparam int NW    = ANGLE_FRAC_BITS + 42;
  localparam int LIMBS = (NW - DivShift + 15) / 16;
  localparam int LW    = LIMBS * 16;
  localparam int LC    = $clog2(LIMBS);

  div_phase_e         phase_q, phase_d;
  logic [1:0]         axis_q;
  logic               neg_q, done_q;
  logic [40:0]        prod_q;
  logic [LW-1:0]      num_q, quo_q;
  logic [20:0]        rem_q;
  logic [15:0]        qe_q;
  logic [LC-1:0]      cnt_q;
  logic signed [21:0] rate_sel, rate_abs;
  logic [NW-1:0]      numer;
  logic [36:0]        cur;
  logic [53:0]        est;
  logic [21:0]        r0;
  logic               ge;
  logic signed [QB:0] qv;

  always_comb begin
    case (axis_q)
      2'd0:    rate_sel = rate_x_i;
      2'd1:    rate_sel = rate_y_i;
      default: rate_sel = rate_z_i;
    endcase
    rate_abs = rate_sel[21] ? -rate_sel : rate_sel;
    numer    = {1'b0, prod_q, {ANGLE_FRAC_BITS{1'b0}}} + NW'(DtDivisor >> 1);
    // partial dividend: running remainder over the next limb
    cur      = {rem_q, num_q[LW-1 -: 16]};
    est      = 54'(cur) * 54'(DivRecip);
    r0       = cur[21:0] - 22'(37'(qe_q) * 37'(DivOdd));
    ge       = r0 >= {1'b0, DivOdd};
    qv       = neg_q ? -$signed({1'b0, quo_q[QB-1:0]}) : $signed({1'b0, quo_q[QB-1:0]});
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      DIV_IDLE:  if (start_i) phase_d = DIV_MUL;
      DIV_MUL:   phase_d = DIV_LOAD;
      DIV_LOAD:  phase_d = DIV_EST;
      DIV_EST:   phase_d = DIV_FIX;
      DIV_FIX:   phase_d = (cnt_q == LC'(LIMBS - 1)) ? DIV_STORE : DIV_EST;
      DIV_STORE: phase_d = (axis_q == 2'd2) ? DIV_IDLE : DIV_MUL;
      default:   phase_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DIV_IDLE;
      axis_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == DIV_STORE) && (axis_q == 2'd2);
      if (phase_q == DIV_IDLE) begin
        axis_q <= '0;
      end else if (phase_q == DIV_STORE) begin
        axis_q <= axis_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      DIV_MUL: begin
        prod_q <= 41'(rate_abs[20:0]) * 41'(us_i);
        neg_q  <= rate_sel[21];
      end
      DIV_LOAD: begin
        // drop the power-of-two factor of the divisor up front
        num_q <= LW'(numer[NW-1:DivShift]);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
      end
      DIV_EST: begin
        qe_q <= est[52:37];
      end
      DIV_FIX: begin
        // estimate is low by at most one; bump it when the remainder overflows
        rem_q <= ge ? 21'(r0 - {1'b0, DivOdd}) : r0[20:0];
        quo_q <= {quo_q[LW-17:0], ge ? qe_q + 16'd1 : qe_q};
        num_q <= {num_q[LW-17:0], 16'b0};
        cnt_q <= cnt_q + LC'(1);
      end
      DIV_STORE: begin
        case (axis_q)
          2'd0:    delta_x_o <= qv;
          2'd1:    delta_y_o <= qv;
          default: delta_z_o <= qv;
        endcase
      end
      default: ;
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== design/imu_complementary_attitude_filter.sv =====
// From input beat to result beat the work runs through two 16-step square roots
// and two CORDIC runs (steps capped at 24) done in turn; the gyro divider
// finishes in the background. No input is taken while a beat is in work.
// A finished result waits in the output register while the next starts.
// Reset clears the angle state and loads default register values.
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter
// Roll/pitch complementary filter with gyro-only yaw, fixed point, built
// around one shared multiplier and iterative sqrt, CORDIC and divider units.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter #(
  parameter int CORDIC_STEPS    = icaf_pkg::CordicStepsDef,
  parameter int ANGLE_FRAC_BITS = icaf_pkg::AngleFracDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input sample channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  input  logic        [19:0] elapsed_us_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] roll_angle_o,
  output logic signed [31:0] pitch_angle_o,
  output logic signed [31:0] yaw_angle_o,
  output logic               accel_trusted_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import icaf_pkg::*;

  localparam int DW = ANGLE_FRAC_BITS + 13;

  // configuration registers
  logic signed [19:0] bias_x_q, bias_y_q, bias_z_q;
  logic signed [15:0] roll_off_q, pitch_off_q;
  logic        [15:0] alpha_q;

  // sequencer and sample
  state_e             state_q, state_d;
  logic signed [16:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic        [19:0] us_q;
  logic        [30:0] sxx_q, syy_q, szz_q;
  logic               trusted_q, div_fin_q;
  logic signed [33:0] atan_r_q, atan_p_q;
  logic signed [53:0] acc_q;
  logic signed [31:0] roll_q, pitch_q, yaw_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_roll_q, out_pitch_q, out_yaw_q;
  logic               out_trust_q;

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod_q;

  // unit handshakes
  logic               isq_start, isq_done, cor_start, cor_done, div_start, div_done;
  logic        [31:0] isq_rad;
  logic        [15:0] isq_root;
  logic signed [16:0] cor_y;
  logic signed [33:0] cor_angle;
  logic signed [21:0] rate_x, rate_y, rate_z;
  logic signed [DW-1:0] dr, dp, dy;

  logic               accept, cfg_wr, out_free, pitch_sel;
  logic        [31:0] s_sum;
  logic signed [33:0] g_sel, a_sel, a_roll, a_pitch, yaw_sum;
  logic signed [53:0] blend_sum;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pready   = 1'b1;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_x_q    <= '0;
      bias_y_q    <= '0;
      bias_z_q    <= '0;
      roll_off_q  <= '0;
      pitch_off_q <= '0;
      alpha_q     <= AlphaReset;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegGyroBiasX:  bias_x_q    <= pwdata[19:0];
        RegGyroBiasY:  bias_y_q    <= pwdata[19:0];
        RegGyroBiasZ:  bias_z_q    <= pwdata[19:0];
        RegRollOffset: roll_off_q  <= pwdata[15:0];
        RegPitchOff:   pitch_off_q <= pwdata[15:0];
        RegAlphaGain:  alpha_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegGyroBiasX:  prdata = {12'b0, bias_x_q};
      RegGyroBiasY:  prdata = {12'b0, bias_y_q};
      RegGyroBiasZ:  prdata = {12'b0, bias_z_q};
      RegRollOffset: prdata = {16'b0, roll_off_q};
      RegPitchOff:   prdata = {16'b0, pitch_off_q};
      RegAlphaGain:  prdata = {16'b0, alpha_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- iterative units ----------------
  // bias-corrected rates: raw rate with 4 fraction bits minus the bias
  assign rate_x = {{1{gx_q[16]}}, gx_q, 4'b0} - {{2{bias_x_q[19]}}, bias_x_q};
  assign rate_y = {{1{gy_q[16]}}, gy_q, 4'b0} - {{2{bias_y_q[19]}}, bias_y_q};
  assign rate_z = {{1{gz_q[16]}}, gz_q, 4'b0} - {{2{bias_z_q[19]}}, bias_z_q};

  assign isq_start = (state_q == S_RS) || (state_q == S_PS);
  assign isq_rad   = (state_q == S_PS) ? ({1'b0, syy_q} + {1'b0, szz_q})
                                       : ({1'b0, sxx_q} + {1'b0, szz_q});
  assign cor_start = (state_q == S_CS) || (state_q == S_QS);
  assign cor_y     = (state_q == S_QS) ? -ax_q : ay_q;
  assign div_start = (state_q == S_LOAD);

  icaf_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (isq_start),
    .radicand_i (isq_rad),
    .done_o     (isq_done),
    .root_o     (isq_root)
  );

  icaf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (cor_y),
    .x_i     (isq_root),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  icaf_gyro_div #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_gyro_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rate_x_i  (rate_x),
    .rate_y_i  (rate_y),
    .rate_z_i  (rate_z),
    .us_i      (us_q),
    .done_o    (div_done),
    .delta_x_o (dr),
    .delta_y_o (dp),
    .delta_z_o (dy)
  );

  // ---------------- blend operands ----------------
  // accel angles minus level offsets (offsets carry 8 fraction bits)
  assign a_roll  = atan_r_q - ({{18{roll_off_q[15]}}, roll_off_q} <<< (ANGLE_FRAC_BITS - 8));
  assign a_pitch = atan_p_q - ({{18{pitch_off_q[15]}}, pitch_off_q} <<< (ANGLE_FRAC_BITS - 8));

  assign pitch_sel = (state_q == S_BP1) || (state_q == S_BP2) || (state_q == S_BP3);
  // gyro-propagated angle: previous state plus this beat's increment
  assign g_sel = pitch_sel
    ? ({{2{pitch_q[31]}}, pitch_q} + {{(34-DW){dp[DW-1]}}, dp})
    : ({{2{roll_q[31]}}, roll_q} + {{(34-DW){dr[DW-1]}}, dr});
  assign a_sel = pitch_sel ? a_pitch : a_roll;

  assign yaw_sum   = {{2{yaw_q[31]}}, yaw_q} + {{(34-DW){dy[DW-1]}}, dy};
  assign blend_sum = acc_q + {{2{prod_q[51]}}, prod_q};
  assign s_sum     = {1'b0, sxx_q} + {1'b0, syy_q} + {1'b0, szz_q};

  // operand select for the shared multiplier
  always_comb begin
    case (state_q)
      S_LOAD: begin
        mul_a = {ax_q[16], ax_q};
        mul_b = {{17{ax_q[16]}}, ax_q};
      end
      S_SQY: begin
        mul_a = {ay_q[16], ay_q};
        mul_b = {{17{ay_q[16]}}, ay_q};
      end
      S_SQZ: begin
        mul_a = {az_q[16], az_q};
        mul_b = {{17{az_q[16]}}, az_q};
      end
      S_BR1, S_BP1: begin
        mul_a = {2'b0, alpha_q};
        mul_b = g_sel;
      end
      default: begin
        mul_a = 18'sd65536 - {2'b0, alpha_q};
        mul_b = a_sel;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_LOAD;
      S_LOAD:  state_d = S_SQY;
      S_SQY:   state_d = S_SQZ;
      S_SQZ:   state_d = S_SQE;
      S_SQE:   state_d = S_RS;
      S_RS:    state_d = S_RW;
      S_RW:    if (isq_done) state_d = S_CS;
      S_CS:    state_d = S_CW;
      S_CW:    if (cor_done) state_d = S_PS;
      S_PS:    state_d = S_PW;
      S_PW:    if (isq_done) state_d = S_QS;
      S_QS:    state_d = S_QW;
      S_QW:    if (cor_done) state_d = S_DW;
      S_DW:    if (div_fin_q) state_d = S_BR1;
      S_BR1:   state_d = S_BR2;
      S_BR2:   state_d = S_BR3;
      S_BR3:   state_d = S_BP1;
      S_BP1:   state_d = S_BP2;
      S_BP2:   state_d = S_BP3;
      S_BP3:   state_d = S_YAW;
      S_YAW:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_fin_q   <= 1'b0;
      out_valid_q <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
    end else begin
      state_q <= state_d;
      // track completion of the gyro divider, which runs in the background
      if (state_q == S_LOAD) begin
        div_fin_q <= 1'b0;
      end else if (div_done) begin
        div_fin_q <= 1'b1;
      end
      if (state_q == S_BR3) begin
        roll_q <= trusted_q ? sat32({{2{blend_sum[53]}}, blend_sum[53:16]})
                            : sat32({{6{g_sel[33]}}, g_sel});
      end
      if (state_q == S_BP3) begin
        pitch_q <= trusted_q ? sat32({{2{blend_sum[53]}}, blend_sum[53:16]})
                             : sat32({{6{g_sel[33]}}, g_sel});
      end
      if (state_q == S_YAW) begin
        yaw_q <= sat32({{6{yaw_sum[33]}}, yaw_sum});
      end
      // hold the result beat until taken; a new one loads only when free
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      // remap axes: x' = -y, y' = x, z' = -z
      ax_q <= -{accel_y_i[15], accel_y_i};
      ay_q <= {accel_x_i[15], accel_x_i};
      az_q <= -{accel_z_i[15], accel_z_i};
      gx_q <= -{gyro_y_i[15], gyro_y_i};
      gy_q <= {gyro_x_i[15], gyro_x_i};
      gz_q <= -{gyro_z_i[15], gyro_z_i};
      us_q <= (elapsed_us_i == 20'd0) ? 20'd1000 : elapsed_us_i;
    end
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_SQY: sxx_q <= prod_q[30:0];
      S_SQZ: syy_q <= prod_q[30:0];
      S_SQE: szz_q <= prod_q[30:0];
      S_RS:  trusted_q <= (s_sum >= TrustLo) && (s_sum <= TrustHi);
      S_CW:  if (cor_done) atan_r_q <= cor_angle;
      S_QW:  if (cor_done) atan_p_q <= cor_angle;
      S_BR2, S_BP2: acc_q <= {{2{prod_q[51]}}, prod_q} + 54'sd32768;
      default: ;
    endcase
    if (state_q == S_OUT && out_free) begin
      out_roll_q  <= roll_q;
      out_pitch_q <= pitch_q;
      out_yaw_q   <= yaw_q;
      out_trust_q <= trusted_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign roll_angle_o    = out_roll_q;
  assign pitch_angle_o   = out_pitch_q;
  assign yaw_angle_o     = out_yaw_q;
  assign accel_trusted_o = out_trust_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the attitude filter: a queue-fed sample driver,
// a result monitor checked against a bit-exact fixed-point predictor, and
// register writes between phases over the register port.
// ----------------------------------------------------------------------------
module tb;
  import icaf_pkg::*;

  localparam int FracBits   = AngleFracDef;
  localparam int CordSteps  = (CordicStepsDef < TblLen) ? CordicStepsDef : TblLen;
  localparam int QuietLen   = 700;   // cycles with no idling per window
  localparam int QuietWin   = 5000;
  localparam int DrainWait  = 120;   // settling wait after the queues empty
  localparam int StuckLimit = 6000;  // cycles without any accepted beat

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic        [19:0] us;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll, pitch, yaw;
    logic               trusted;
  } attitude_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall_o;
  sample_t            drv = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic signed [31:0] roll_angle_o, pitch_angle_o, yaw_angle_o;
  logic               accel_trusted_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic        [4:0]  paddr = '0;
  logic        [31:0] pwdata = '0;
  logic        [31:0] prdata;
  logic               pready;

  sample_t   pending_samples[$];
  attitude_t expected_attitude[$];
  int        err_count = 0;
  int        cyc = 0;
  int        stuck = 0;

  // predictor copy of the filter state and registers
  longint roll_st, pitch_st, yaw_st;
  longint bias_x, bias_y, bias_z, roll_off, pitch_off, alpha;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  imu_complementary_attitude_filter u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .accel_x_i(drv.ax), .accel_y_i(drv.ay), .accel_z_i(drv.az),
    .gyro_x_i(drv.gx), .gyro_y_i(drv.gy), .gyro_z_i(drv.gz),
    .elapsed_us_i(drv.us),
    .out_valid_o, .out_stall_i(out_stall),
    .roll_angle_o, .pitch_angle_o, .yaw_angle_o, .accel_trusted_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC, x >= 0; degrees with FracBits fraction bits
  function automatic longint vec_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < CordSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_deg(i[4:0]));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_deg(i[4:0]));
      end
    end
    return (z + (64'sd1 << (TblFrac - FracBits - 1))) >>> (TblFrac - FracBits);
  endfunction

  // rate16 * us * 2^F / 2096000000, rounded half away from zero
  function automatic longint turn_step(longint rate, longint unsigned us);
    longint unsigned mag;
    mag = longint'(rate < 0 ? -rate : rate) * us;
    mag = mag << FracBits;
    mag = (mag + 64'd1048000000) / 64'd2096000000;
    return rate < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint mix(longint g, longint a, bit trusted);
    if (!trusted) return clamp32(g);
    return clamp32((alpha * g + (65536 - alpha) * a + 32768) >>> 16);
  endfunction

  function automatic attitude_t predict_attitude(sample_t smp);
    longint ax, ay, az, gx, gy, gz, sxx, syy, szz, acc_r, acc_p;
    longint unsigned us;
    bit trusted;
    attitude_t res;
    ax = -longint'(smp.ay); ay = longint'(smp.ax); az = -longint'(smp.az);
    gx = -longint'(smp.gy); gy = longint'(smp.gx); gz = -longint'(smp.gz);
    sxx = ax * ax; syy = ay * ay; szz = az * az;
    trusted = (sxx + syy + szz >= longint'(TrustLo)) && (sxx + syy + szz <= longint'(TrustHi));
    acc_r = vec_angle(ay, root_floor(sxx + szz)) - roll_off * (64'sd1 << (FracBits - 8));
    acc_p = vec_angle(-ax, root_floor(syy + szz)) - pitch_off * (64'sd1 << (FracBits - 8));
    us = (smp.us == 0) ? 64'd1000 : 64'(smp.us);
    roll_st  = mix(roll_st + turn_step(gx * 16 - bias_x, us), acc_r, trusted);
    pitch_st = mix(pitch_st + turn_step(gy * 16 - bias_y, us), acc_p, trusted);
    yaw_st   = clamp32(yaw_st + turn_step(gz * 16 - bias_z, us));
    res.roll = roll_st[31:0];
    res.pitch = pitch_st[31:0];
    res.yaw = yaw_st[31:0];
    res.trusted = trusted;
    return res;
  endfunction

  // idle with a 35 percent chance, except in a quiet stretch of each window
  function automatic bit want_idle();
    if ((cyc % QuietWin) < QuietLen) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  always @(posedge clk_i) cyc <= cyc + 1;

  // ---------------------------------------------------------------------------
  // Driver: hold the beat until accepted, predict on accept, then advance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall_o) begin
        expected_attitude.push_back(predict_attitude(drv));
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_samples.size() > 0 && !want_idle()) begin
          drv <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    attitude_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_attitude.size() == 0) begin
          $display("%0t: result beat with no expectation pending", $realtime);
          err_count++;
        end else begin
          want = expected_attitude.pop_front();
          if (roll_angle_o !== want.roll) report_mismatch("roll", roll_angle_o, want.roll);
          if (pitch_angle_o !== want.pitch)
            report_mismatch("pitch", pitch_angle_o, want.pitch);
          if (yaw_angle_o !== want.yaw) report_mismatch("yaw", yaw_angle_o, want.yaw);
          if (accel_trusted_o !== want.trusted)
            report_mismatch("accel_trusted", accel_trusted_o, want.trusted);
        end
      end
      out_stall <= want_idle();
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= StuckLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] idx, longint val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegGyroBiasX:  bias_x = val;
      RegGyroBiasY:  bias_y = val;
      RegGyroBiasZ:  bias_z = val;
      RegRollOffset: roll_off = val;
      RegPitchOff:   pitch_off = val;
      RegAlphaGain:  alpha = val;
      default: ;
    endcase
  endtask

  task automatic write_all(longint bx, longint by, longint bz, longint ro, longint po,
                           longint al);
    reg_write(RegGyroBiasX, bx);
    reg_write(RegGyroBiasY, by);
    reg_write(RegGyroBiasZ, bz);
    reg_write(RegRollOffset, ro);
    reg_write(RegPitchOff, po);
    reg_write(RegAlphaGain, al);
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid && expected_attitude.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int gz, int us);
    sample_t s;
    s.ax = ax[15:0]; s.ay = ay[15:0]; s.az = az[15:0];
    s.gx = gx[15:0]; s.gy = gy[15:0]; s.gz = gz[15:0];
    s.us = us[19:0];
    return s;
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  // mostly a near-1g accel with modest rates; the rest full-range noise
  function automatic sample_t rand_sample(bit spin);
    sample_t s;
    int ax, ay, az, k;
    real f, r;
    k = $urandom_range(99);
    if (k < 70) begin
      f = 0.8 + 0.4 * ($urandom_range(1000) / 1000.0);
      ax = $urandom_range(22000) - 11000;
      ay = $urandom_range(22000) - 11000;
      r = (16384.0 * f) * (16384.0 * f) - ax * ax - ay * ay;
      az = (r > 0.0) ? int'($sqrt(r)) : 0;
      if ($urandom_range(1)) az = -az;
      s = mk(ax, ay, az, $urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
             $urandom_range(8000) - 4000, $urandom_range(1500));
    end else begin
      s = mk(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), int'($urandom_range(1048575)));
    end
    if (spin) begin
      s.gz = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.gx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      s.us = 20'hfffff - 20'($urandom_range(1000));
    end
    return s;
  endfunction

  initial begin
    roll_st = 0; pitch_st = 0; yaw_st = 0;
    bias_x = 0; bias_y = 0; bias_z = 0; roll_off = 0; pitch_off = 0;
    alpha = longint'(AlphaReset);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: field extremes, zero elapsed time, zero accel, trusted level
    pending_samples.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(mk(0, 0, 16384, 0, 0, 0, 0));
    pending_samples.push_back(mk(0, 0, -16384, 131, -131, 262, 1000));
    pending_samples.push_back(mk(16384, 0, 0, 0, 0, 0, 1000));
    pending_samples.push_back(mk(0, -16384, 0, 0, 0, 0, 1000));
    pending_samples.push_back(mk(0, 0, 13926, 0, 0, 0, 500));
    pending_samples.push_back(mk(0, 0, 13927, 0, 0, 0, 500));
    pending_samples.push_back(mk(0, 0, 18842, 0, 0, 0, 500));
    pending_samples.push_back(mk(0, 0, 18843, 0, 0, 0, 500));
    pending_samples.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 1048575));
    pending_samples.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 1048575));
    pending_samples.push_back(mk(32767, -32768, 0, -32768, 32767, 0, 1));
    pending_samples.push_back(mk(0, 32767, 0, 1, -1, 1, 0));
    pending_samples.push_back(mk(11585, 11585, 0, -1, 1, -1, 2000));
    pending_samples.push_back(mk(-9459, 9459, 9459, 65, -66, 0, 999));
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(0, 0, 0, 0, 0, longint'(AlphaReset));
        1: write_all(524287, -524288, 524287, 23040, -23040, 0);
        2: write_all(-524288, 524287, -524288, -23040, 23040, 65535);
        3: write_all(0, 0, 524287, 0, 0, 65535);
        4: write_all(0, 0, -524288, 0, 0, 1);
        default: write_all(longint'($urandom_range(1048575)) - 524288,
                           longint'($urandom_range(1048575)) - 524288,
                           longint'($urandom_range(1048575)) - 524288,
                           longint'($urandom_range(46080)) - 23040,
                           longint'($urandom_range(46080)) - 23040,
                           longint'($urandom_range(65535)));
      endcase
      // phases 3 and 4 spin the gyros hard enough to saturate the angles
      for (int n = 0; n < 112; n++) pending_samples.push_back(rand_sample(ph == 3 || ph == 4));
      drain();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
